/* sv/bellman_ford_shortest_paths_core_macros.svh */
// assertion macros for the shortest path core
`ifndef BELLMAN_FORD_SHORTEST_PATHS_CORE_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BFSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bfsp_pkg.sv */
// types and constants of the shortest path core
`default_nettype none
package bfsp_pkg;
   localparam int VTX_W  = 6;
   localparam int VCNT_W = 7;
   localparam int SRC_W  = 6;
   localparam int WGT_W  = 16;
   localparam int DIST_W = 32;
   localparam int ARC_W  = 28;
   localparam int CSR_AW = 3;
   localparam logic signed [DIST_W-1:0] DIST_INF = 32'sh7FFF_FFFF;
   localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;
   localparam logic [CSR_AW-1:0] CSR_NUM_VERTICES = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_SOURCE_VERTEX = 3'd4;

   typedef struct packed {
      logic [VTX_W-1:0]        from_vertex;
      logic [VTX_W-1:0]        to_vertex;
      logic signed [WGT_W-1:0] weight;
      logic                    last_edge;
   } req_word_type;

   typedef struct packed {
      logic [VTX_W-1:0]         vertex;
      logic signed [DIST_W-1:0] distance;
      logic                     reachable;
      logic                     edges_dropped;
      logic                     last_vertex;
   } rsp_word_type;

   typedef struct packed {
      logic [VTX_W-1:0]        from_vertex;
      logic [VTX_W-1:0]        to_vertex;
      logic signed [WGT_W-1:0] weight;
   } arc_type;

   typedef struct packed {
      logic [VTX_W-1:0] addr_a;
      logic [VTX_W-1:0] addr_b;
   } dist_rd_type;

   typedef struct packed {
      logic                     en;
      logic [VTX_W-1:0]         addr;
      logic signed [DIST_W-1:0] value;
   } dist_wr_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] value_a;
      logic                     reached_a;
      logic signed [DIST_W-1:0] value_b;
      logic                     reached_b;
   } dist_rdata_type;
endpackage
`default_nettype wire

/* sv/bfsp_dist_store.sv */
// distance memory with per-entry reached bits and two registered read ports
`default_nettype none
module bfsp_dist_store #(
   parameter int MAX_VERTICES = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       clear,
   input  bfsp_pkg::dist_rd_type     rd,
   input  bfsp_pkg::dist_wr_type     wr,
   output bfsp_pkg::dist_rdata_type  rdata
);
   localparam int VW = $clog2(MAX_VERTICES);

   logic signed [bfsp_pkg::DIST_W-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] vld_ff;
   logic [MAX_VERTICES-1:0] vld_in;
   logic signed [bfsp_pkg::DIST_W-1:0] rd_a_ff, rd_b_ff;
   logic vld_a_ff, vld_b_ff;

   always_comb begin
      vld_in = vld_ff;
      if (clear) begin
         vld_in = '0;
      end else if (wr.en) begin
         vld_in[wr.addr[VW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[VW-1:0]] <= wr.value;
      end
      rd_a_ff  <= mem[rd.addr_a[VW-1:0]];
      rd_b_ff  <= mem[rd.addr_b[VW-1:0]];
      vld_a_ff <= vld_ff[rd.addr_a[VW-1:0]];
      vld_b_ff <= vld_ff[rd.addr_b[VW-1:0]];
   end

   // unreached entries read as infinity
   assign rdata.value_a   = vld_a_ff ? rd_a_ff : bfsp_pkg::DIST_INF;
   assign rdata.reached_a = vld_a_ff;
   assign rdata.value_b   = vld_b_ff ? rd_b_ff : bfsp_pkg::DIST_INF;
   assign rdata.reached_b = vld_b_ff;
endmodule
`default_nettype wire

/* sv/bellman_ford_shortest_paths_core.sv */
// top level of the bellman-ford shortest path core
// channel   ports                          direction  handshake
// request   start, busy, req_word          in         start & !busy
// response  rsp_valid, rsp_word            out        rsp_valid, one cycle, no stall
// csr       psel, penable, pwrite, paddr   in         apb write, pready tied high
// a word without last_edge is written into the arc memory while it has room, else edges_dropped is set
// a last word starts the run: an init state, then for each stored arc in each
//   of (nv-1) rounds the states ARD, DRD, SUM and WRB, set by the single-port arc
//   memory and the read-modify-write of the distance memory, then one result per vertex
// reset is synchronous; distances clear through reached bits, no clearing pass
`default_nettype none
`include "bellman_ford_shortest_paths_core_macros.svh"
module bellman_ford_shortest_paths_core #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_ARCS     = 1024
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  bfsp_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   output bfsp_pkg::rsp_word_type            rsp_word,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire [bfsp_pkg::CSR_AW-1:0]        paddr,
   input  wire [31:0]                        pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   localparam int AW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
   localparam int CW = $clog2(MAX_ARCS + 1);
   localparam int VCW = bfsp_pkg::VCNT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_ARD   = 3'd2;
   localparam logic [2:0] ST_DRD   = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_WRB   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;
   localparam logic [2:0] ST_DRAIN = 3'd7;

   // configuration registers
   logic [VCW-1:0] nv_cfg_ff, nv_cfg_in;
   logic [bfsp_pkg::SRC_W-1:0] src_cfg_ff, src_cfg_in;
   logic csr_wr;

   // control state
   logic [2:0] state_ff, state_in;
   logic [CW-1:0] arc_cnt_ff, arc_cnt_in;
   logic ovf_ff, ovf_in;
   logic [CW-1:0] k_ff, k_in;
   logic [VCW-1:0] round_ff, round_in;
   logic [bfsp_pkg::VTX_W-1:0] out_idx_ff, out_idx_in;
   logic emit_ff, emit_in;
   logic last_ff, last_in;
   logic [bfsp_pkg::VTX_W-1:0] emit_idx_ff, emit_idx_in;

   // relaxation datapath
   bfsp_pkg::arc_type arc_mem [MAX_ARCS];
   bfsp_pkg::arc_type arc_rd_ff;
   logic in_range_ff;
   logic ok_ff;
   logic signed [bfsp_pkg::DIST_W-1:0] sum_ff;
   logic signed [bfsp_pkg::DIST_W:0] sum_wide;
   logic signed [bfsp_pkg::DIST_W-1:0] sum_sat;
   logic [VCW-1:0] nv_eff;
   logic accept, arc_wr, upd, src_ok;

   bfsp_pkg::dist_rd_type    dist_rd;
   bfsp_pkg::dist_wr_type    dist_wr;
   bfsp_pkg::dist_rdata_type dist_rdata;
   logic dist_clear;

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;
   always_comb begin
      nv_cfg_in  = nv_cfg_ff;
      src_cfg_in = src_cfg_ff;
      if (csr_wr) begin
         case (paddr)
            bfsp_pkg::CSR_NUM_VERTICES: begin
               nv_cfg_in = pwdata[VCW-1:0];
            end
            bfsp_pkg::CSR_SOURCE_VERTEX: begin
               src_cfg_in = pwdata[bfsp_pkg::SRC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end
   always_comb begin
      case (paddr)
         bfsp_pkg::CSR_NUM_VERTICES:  prdata = {{(32-VCW){1'b0}}, nv_cfg_ff};
         bfsp_pkg::CSR_SOURCE_VERTEX: prdata = {{(32-bfsp_pkg::SRC_W){1'b0}}, src_cfg_ff};
         default:                     prdata = '0;
      endcase
   end

   // vertex count clamped into 1..MAX_VERTICES
   always_comb begin
      if (nv_cfg_ff == '0) begin
         nv_eff = VCW'(1);
      end else if (nv_cfg_ff > VCW'(MAX_VERTICES)) begin
         nv_eff = VCW'(MAX_VERTICES);
      end else begin
         nv_eff = nv_cfg_ff;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;
   assign arc_wr = accept & (arc_cnt_ff < CW'(MAX_ARCS));
   assign src_ok = ({1'b0, src_cfg_ff} < nv_eff);

   // arc memory: one write port while loading, one registered read port
   always_ff @(posedge clock) begin
      if (arc_wr) begin
         arc_mem[arc_cnt_ff[AW-1:0]] <= '{from_vertex: req_word.from_vertex,
                                          to_vertex:   req_word.to_vertex,
                                          weight:      req_word.weight};
      end
      arc_rd_ff <= arc_mem[k_ff[AW-1:0]];
   end

   // distance reads: arc endpoints while relaxing, vertex index while emitting
   assign dist_rd.addr_a = (state_ff == ST_OUT) ? out_idx_ff : arc_rd_ff.from_vertex;
   assign dist_rd.addr_b = arc_rd_ff.to_vertex;

   // saturating add of distance and sign-extended weight
   assign sum_wide = {dist_rdata.value_a[bfsp_pkg::DIST_W-1], dist_rdata.value_a}
                   + {{(bfsp_pkg::DIST_W + 1 - bfsp_pkg::WGT_W){arc_rd_ff.weight[bfsp_pkg::WGT_W-1]}},
                      arc_rd_ff.weight};
   always_comb begin
      if (sum_wide[bfsp_pkg::DIST_W] != sum_wide[bfsp_pkg::DIST_W-1]) begin
         sum_sat = sum_wide[bfsp_pkg::DIST_W] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_INF;
      end else begin
         sum_sat = sum_wide[bfsp_pkg::DIST_W-1:0];
      end
   end

   // relax only from a reached vertex, only along an arc inside the graph, and only on a strict improvement
   assign upd = ok_ff & (sum_ff < dist_rdata.value_b);

   always_ff @(posedge clock) begin
      in_range_ff <= ({1'b0, arc_rd_ff.from_vertex} < nv_eff)
                   & ({1'b0, arc_rd_ff.to_vertex} < nv_eff);
      ok_ff  <= in_range_ff & dist_rdata.reached_a;
      sum_ff <= sum_sat;
   end

   always_comb begin
      dist_wr.en    = 1'b0;
      dist_wr.addr  = arc_rd_ff.to_vertex;
      dist_wr.value = sum_ff;
      if (state_ff == ST_INIT) begin
         dist_wr.en    = src_ok;
         dist_wr.addr  = src_cfg_ff;
         dist_wr.value = '0;
      end else if (state_ff == ST_WRB) begin
         dist_wr.en = upd;
      end
   end

   assign dist_clear = (state_ff == ST_DRAIN);

   bfsp_dist_store #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dist (
      .clock (clock),
      .reset (reset),
      .clear (dist_clear),
      .rd    (dist_rd),
      .wr    (dist_wr),
      .rdata (dist_rdata)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      arc_cnt_in  = arc_cnt_ff;
      ovf_in      = ovf_ff;
      k_in        = k_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      emit_in     = 1'b0;
      last_in     = last_ff;
      emit_idx_in = emit_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (arc_wr) begin
                  arc_cnt_in = arc_cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_word.last_edge) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            k_in       = '0;
            round_in   = VCW'(1);
            out_idx_in = '0;
            if ((nv_eff > VCW'(1)) && (arc_cnt_ff != '0)) begin
               state_in = ST_ARD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ARD: begin
            state_in = ST_DRD;
         end
         ST_DRD: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_WRB;
         end
         ST_WRB: begin
            state_in = ST_ARD;
            if (k_ff == arc_cnt_ff - CW'(1)) begin
               k_in     = '0;
               round_in = round_ff + VCW'(1);
               if (round_ff == nv_eff - VCW'(1)) begin
                  state_in = ST_OUT;
               end
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         ST_OUT: begin
            emit_in     = 1'b1;
            emit_idx_in = out_idx_ff;
            last_in     = ({1'b0, out_idx_ff} == nv_eff - VCW'(1));
            out_idx_in  = out_idx_ff + bfsp_pkg::VTX_W'(1);
            if ({1'b0, out_idx_ff} == nv_eff - VCW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            arc_cnt_in = '0;
            ovf_in     = 1'b0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         arc_cnt_ff <= '0;
         ovf_ff     <= 1'b0;
         emit_ff    <= 1'b0;
         nv_cfg_ff  <= VCW'(64);
         src_cfg_ff <= '0;
      end else begin
         state_ff   <= state_in;
         arc_cnt_ff <= arc_cnt_in;
         ovf_ff     <= ovf_in;
         emit_ff    <= emit_in;
         nv_cfg_ff  <= nv_cfg_in;
         src_cfg_ff <= src_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      round_ff    <= round_in;
      out_idx_ff  <= out_idx_in;
      last_ff     <= last_in;
      emit_idx_ff <= emit_idx_in;
   end

   // response word, shown the cycle after the distance read
   assign rsp_valid              = emit_ff;
   assign rsp_word.vertex        = emit_idx_ff;
   assign rsp_word.distance      = dist_rdata.value_a;
   assign rsp_word.reachable     = dist_rdata.reached_a;
   assign rsp_word.edges_dropped = ovf_ff;
   assign rsp_word.last_vertex   = last_ff;

   `BFSP_ASSERT_NOW(a_rsp_only_busy, rsp_valid, busy, "response word while idle")
   `BFSP_ASSERT_NEXT(a_last_starts_run, accept && req_word.last_edge, busy,
                     "last word did not start a run")
   `BFSP_ASSERT_NEXT(a_last_ends_burst, rsp_valid && rsp_word.last_vertex, !rsp_valid,
                     "response after last vertex")
   `BFSP_ASSERT_NOW(a_unreached_inf, rsp_valid && !rsp_word.reachable,
                    rsp_word.distance == bfsp_pkg::DIST_INF, "unreached vertex not infinite")
   `BFSP_ASSERT_NOW(a_count_bound, 1'b1, arc_cnt_ff <= CW'(MAX_ARCS), "arc count overran")
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// testbench of the bellman-ford shortest path core: arc loading, relaxation and csr settings
`timescale 1ns / 100ps
module tb;
   localparam int MAX_V = 64;
   localparam int MAX_A = 1024;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bfsp_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   bfsp_pkg::rsp_word_type rsp_word;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [bfsp_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   bellman_ford_shortest_paths_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // shadow copy of the block's state
   logic [6:0] vcount_reg = 7'd64;
   logic [5:0] source_reg = 6'd0;
   logic [5:0] arc_from [MAX_A];
   logic [5:0] arc_to [MAX_A];
   logic signed [15:0] arc_wgt [MAX_A];
   int arc_total = 0;
   bit arcs_lost = 0;
   logic signed [31:0] last_dist [MAX_V];

   bfsp_pkg::rsp_word_type dist_queue [$];
   int errors = 0;
   int words_sent = 0;
   int runs_done = 0;
   int results_seen = 0;
   longint cycles = 0;

   // relax over the stored arcs and queue one expected word per vertex
   task automatic solve_graph();
      int nv;
      logic signed [31:0] best [MAX_V];
      bit hit [MAX_V];
      longint sum;
      logic signed [31:0] sat;
      bfsp_pkg::rsp_word_type w;
      nv = (vcount_reg == 0) ? 1 : (vcount_reg > MAX_V) ? MAX_V : vcount_reg;
      for (int i = 0; i < MAX_V; i++) begin
         best[i] = bfsp_pkg::DIST_INF;
         hit[i] = 0;
      end
      if (source_reg < nv) begin
         best[source_reg] = 0;
         hit[source_reg] = 1;
      end
      for (int r = 1; r < nv; r++) begin
         for (int k = 0; k < arc_total; k++) begin
            if (arc_from[k] >= nv || arc_to[k] >= nv || !hit[arc_from[k]]) continue;
            sum = longint'(best[arc_from[k]]) + longint'(arc_wgt[k]);
            // sums clip at the signed 32-bit limits
            if (sum > longint'(bfsp_pkg::DIST_INF)) sat = bfsp_pkg::DIST_INF;
            else if (sum < longint'(bfsp_pkg::DIST_MIN)) sat = bfsp_pkg::DIST_MIN;
            else sat = sum[31:0];
            if (sat < best[arc_to[k]]) begin
               best[arc_to[k]] = sat;
               hit[arc_to[k]] = 1;
            end
         end
      end
      for (int i = 0; i < nv; i++) begin
         w.vertex = i[5:0];
         w.distance = best[i];
         w.reachable = hit[i];
         w.edges_dropped = arcs_lost;
         w.last_vertex = (i == nv - 1);
         dist_queue = {dist_queue, w};
         last_dist[i] = best[i];
      end
      arc_total = 0;
      arcs_lost = 0;
      runs_done++;
   endtask

   task automatic store_arc(input bfsp_pkg::req_word_type w);
      if (arc_total < MAX_A) begin
         arc_from[arc_total] = w.from_vertex;
         arc_to[arc_total] = w.to_vertex;
         arc_wgt[arc_total] = w.weight;
         arc_total++;
      end else begin
         arcs_lost = 1;
      end
      if (w.last_edge) solve_graph();
   endtask

   // accepted words feed the predictor, result words are checked in order
   always @(posedge clock) begin
      bfsp_pkg::rsp_word_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) begin
            store_arc(req_word);
            words_sent++;
         end
         if (rsp_valid) begin
            results_seen++;
            if (dist_queue.size() == 0) begin
               $error("result word with nothing expected: vertex %0d", rsp_word.vertex);
               errors++;
            end else begin
               e = dist_queue.pop_front();
               if (rsp_word.vertex !== e.vertex) begin
                  $error("vertex: expected %0d, got %0d", e.vertex, rsp_word.vertex);
                  errors++;
               end
               if (rsp_word.distance !== e.distance) begin
                  $error("distance: expected %0d, got %0d", e.distance, rsp_word.distance);
                  errors++;
               end
               if (rsp_word.reachable !== e.reachable) begin
                  $error("reachable: expected %0b, got %0b", e.reachable, rsp_word.reachable);
                  errors++;
               end
               if (rsp_word.edges_dropped !== e.edges_dropped) begin
                  $error("edges_dropped: expected %0b, got %0b", e.edges_dropped,
                         rsp_word.edges_dropped);
                  errors++;
               end
               if (rsp_word.last_vertex !== e.last_vertex) begin
                  $error("last_vertex: expected %0b, got %0b", e.last_vertex,
                         rsp_word.last_vertex);
                  errors++;
               end
            end
         end
      end
   end

   // present one word and hold it until the core takes it, then leave start low for the gap, if any
   task automatic send_arc(input int f, input int t, input int w, input bit last,
                           input int gap);
      @(negedge clock);
      start <= 1'b1;
      req_word <= '{from_vertex: f[5:0], to_vertex: t[5:0], weight: w[15:0],
                    last_edge: last};
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold off until every expected word is back and the run has wound down
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (dist_queue.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // apb write: setup phase, then access phase
   task automatic csr_write(input logic [bfsp_pkg::CSR_AW-1:0] addr,
                            input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == bfsp_pkg::CSR_NUM_VERTICES) vcount_reg = data[6:0];
      else if (addr == bfsp_pkg::CSR_SOURCE_VERTEX) source_reg = data[5:0];
   endtask

   task automatic set_graph(input int nv, input int src);
      drain();
      csr_write(bfsp_pkg::CSR_NUM_VERTICES, nv);
      csr_write(bfsp_pkg::CSR_SOURCE_VERTEX, src);
   endtask

   typedef struct {
      bit cfg;
      int nv;
      int src;
      int f;
      int t;
      int w;
      bit last;
      bit known;
      int vtx;
      logic signed [31:0] want_dist;
   } step_row_type;

   // directed graphs; known rows carry the distance of one vertex worked by hand
   step_row_type steps [] = '{
      // weights at both extremes, a direct arc of the most negative weight beats a chain
      '{1, 4, 0, 0, 1, 5, 0, 0, 0, 0},
      '{0, 0, 0, 1, 2, -3, 0, 0, 0, 0},
      '{0, 0, 0, 2, 3, 32767, 0, 0, 0, 0},
      '{0, 0, 0, 0, 3, -32768, 1, 1, 3, -32768},
      // never relaxed from an unreached vertex
      '{0, 0, 0, 1, 2, 7, 1, 1, 2, 32'sh7FFF_FFFF},
      // arcs touching vertices outside the graph are skipped
      '{0, 0, 0, 0, 63, 1, 0, 0, 0, 0},
      '{0, 0, 0, 63, 0, -1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 1, -1, 1, 1, 1, -1},
      // vertex count zero acts as one
      '{1, 0, 0, 0, 0, -5, 1, 1, 0, 0},
      // oversized vertex count clamps to the full graph
      '{1, 127, 63, 63, 0, 100, 1, 1, 0, 100},
      // source outside the graph reaches nothing
      '{1, 2, 5, 0, 1, 1, 1, 1, 1, 32'sh7FFF_FFFF},
      '{1, 3, 2, 2, 1, 3, 0, 0, 0, 0},
      '{0, 0, 0, 1, 0, 4, 1, 1, 0, 7}
   };

   initial begin
      int nv, src, n_arcs, gap;
      bit bursty;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].cfg) set_graph(steps[i].nv, steps[i].src);
         send_arc(steps[i].f, steps[i].t, steps[i].w, steps[i].last, $urandom_range(0, 2));
         if (steps[i].known) begin
            // let the monitor take the word before the prediction is read
            @(negedge clock);
            if (last_dist[steps[i].vtx] !== steps[i].want_dist) begin
               $error("distance of vertex %0d: expected %0d, predicted %0d", steps[i].vtx,
                      steps[i].want_dist, last_dist[steps[i].vtx]);
               errors++;
            end
         end
      end

      // a full store of negative self loops: 63 rounds of 1024 relaxations, one arc lost
      set_graph(64, 0);
      for (int k = 0; k <= MAX_A; k++) send_arc(0, 0, -32768, k == MAX_A, 0);
      @(negedge clock);
      if (last_dist[0] !== 32'sh8200_0000) begin
         $error("distance of vertex 0: expected %0d, predicted %0d", 32'sh8200_0000,
                last_dist[0]);
         errors++;
      end

      // random graphs, mostly small, with random source and occasional stray arcs
      while (words_sent < MAX_A + 1 + steps.size() + 400) begin
         nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10);
         src = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 9);
         set_graph(nv, src);
         bursty = $urandom_range(0, 2) == 0;
         repeat ($urandom_range(1, 4)) begin
            n_arcs = (nv > 16) ? $urandom_range(1, 4) : $urandom_range(1, 14);
            for (int k = 0; k < n_arcs; k++) begin
               gap = bursty ? 0 : $urandom_range(0, 7);
               if ($urandom_range(0, 9) == 0)
                  send_arc($urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                           k == n_arcs - 1, gap);
               else
                  send_arc($urandom_range(0, 9), $urandom_range(0, 9), $urandom,
                           k == n_arcs - 1, gap);
            end
         end
      end

      drain();
      repeat (40) @(negedge clock);
      $display("covered %0d arc words over %0d runs, %0d vertex results checked",
               words_sent, runs_done, results_seen);
      $display("including store overflow, deep negative sums, clamped counts and outside sources");
      if (errors == 0 && dist_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+sv
sv/bfsp_pkg.sv
sv/bfsp_dist_store.sv
sv/bellman_ford_shortest_paths_core.sv
tb/sv/tb.sv
